FILE: sv/unordered_handle_list_macros.svh
// Assertion macros used by the checker file of the handle list.
// No dependencies; clock and reset are taken from the enclosing scope (clk, rst).
`ifndef UNORDERED_HANDLE_LIST_MACROS_SVH
`define UNORDERED_HANDLE_LIST_MACROS_SVH

// Check a property on every clock edge outside reset
`define UHL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define UHL_ASSERT_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/ulist_pkg.sv
// Types and constants of the unordered handle list.
// No dependencies; used by every module of the block.
`default_nettype none

package ulist_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int DATA_W       = 32;
  localparam int POS_W        = 6;
  localparam int CNT_W        = 7;

  typedef enum logic [2:0] {
    MODE_PUSH   = 3'd0,
    MODE_POP    = 3'd1,
    MODE_DELETE = 3'd2,
    MODE_INSERT = 3'd3,
    MODE_FIND   = 3'd4,
    MODE_SET    = 3'd5,
    MODE_READ   = 3'd6
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_FULL     = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_ZERO     = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RD1,
    S_RD2,
    S_WR2,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic [POS_W-1:0]  slot;
    logic [CNT_W-1:0]  count;
    status_t           status;
  } res_t;

endpackage

`default_nettype wire

FILE: sv/ulist_mem.sv
// Handle storage: one write port, one read port with registered read data.
// Depends on ulist_pkg for the data width.
`default_nettype none

module ulist_mem #(
  parameter int CAPACITY = ulist_pkg::CAPACITY_DEF,
  localparam int AW = $clog2(CAPACITY)
) (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [AW-1:0]               waddr,
  input  wire logic [ulist_pkg::DATA_W-1:0] wdata,
  input  wire logic [AW-1:0]               raddr,
  output logic      [ulist_pkg::DATA_W-1:0] rdata
);

  logic [ulist_pkg::DATA_W-1:0] entries [CAPACITY];

  // Write slot
  always_ff @(posedge clk) begin
    if (we) begin
      entries[waddr] <= wdata;
    end
  end

  // Read slot, read data registered
  always_ff @(posedge clk) begin
    rdata <= entries[raddr];
  end

endmodule

`default_nettype wire

FILE: sv/ulist_seq.sv
// Sequencer of the handle list: checks a request, drives the storage ports
// step by step and compares handles during find. Depends on ulist_pkg.
`default_nettype none

module ulist_seq #(
  parameter int CAPACITY = ulist_pkg::CAPACITY_DEF,
  localparam int AW = $clog2(CAPACITY),
  localparam int LW = $clog2(CAPACITY + 1)
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         req_valid,
  output logic                              req_ready,
  input  wire logic [2:0]                   req_mode,
  input  wire logic [ulist_pkg::DATA_W-1:0] req_handle,
  input  wire logic [ulist_pkg::POS_W-1:0]  req_pos,
  output logic                              mem_we,
  output logic      [AW-1:0]                mem_waddr,
  output logic      [ulist_pkg::DATA_W-1:0] mem_wdata,
  output logic      [AW-1:0]                mem_raddr,
  input  wire logic [ulist_pkg::DATA_W-1:0] mem_rdata,
  output logic                              res_valid,
  input  wire logic                         res_ready,
  output ulist_pkg::res_t                   res
);

  // Compare width: holds a length and a position
  localparam int CMPW = (LW > ulist_pkg::CNT_W) ? LW : ulist_pkg::CNT_W;

  ulist_pkg::state_t state, state_next;
  logic [LW-1:0]     length, length_next;

  ulist_pkg::mode_t             r_mode;
  logic [ulist_pkg::DATA_W-1:0] r_handle;
  logic [ulist_pkg::POS_W-1:0]  r_pos;

  logic [ulist_pkg::DATA_W-1:0] value, value_next;
  logic [ulist_pkg::POS_W-1:0]  slot, slot_next;
  ulist_pkg::status_t           status, status_next;

  logic [CMPW-1:0] scan_idx, scan_idx_next;
  logic [CMPW-1:0] cmp_idx, cmp_idx_next;
  logic            cmp_valid, cmp_valid_next;

  logic [CMPW-1:0] len_ext, len_m1, pos_ext;
  logic [AW-1:0]   len_addr, last_addr, pos_addr;
  logic            zero_handle, full, empty, match;

  assign len_ext     = CMPW'(length);
  assign len_m1      = len_ext - CMPW'(1);
  assign pos_ext     = CMPW'(r_pos);
  assign len_addr    = len_ext[AW-1:0];
  assign last_addr   = len_m1[AW-1:0];
  assign pos_addr    = pos_ext[AW-1:0];
  assign zero_handle = (r_handle == '0);
  assign full        = (len_ext == CMPW'(CAPACITY));
  assign empty       = (length == '0);
  assign match       = cmp_valid && (mem_rdata == r_handle);

  assign res.value  = value;
  assign res.slot   = slot;
  assign res.count  = len_ext[ulist_pkg::CNT_W-1:0];
  assign res.status = status;

  // Latch the request
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      r_mode   <= ulist_pkg::mode_t'(req_mode);
      r_handle <= req_handle;
      r_pos    <= req_pos;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ulist_pkg::S_IDLE;
      length    <= '0;
      cmp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      length    <= length_next;
      cmp_valid <= cmp_valid_next;
    end
  end

  // Result and scan registers
  always_ff @(posedge clk) begin
    value    <= value_next;
    slot     <= slot_next;
    status   <= status_next;
    scan_idx <= scan_idx_next;
    cmp_idx  <= cmp_idx_next;
  end

  // Next state, storage ports and result
  always_comb begin
    state_next     = state;
    length_next    = length;
    value_next     = value;
    slot_next      = slot;
    status_next    = status;
    scan_idx_next  = scan_idx;
    cmp_idx_next   = cmp_idx;
    cmp_valid_next = cmp_valid;
    mem_we         = 1'b0;
    mem_waddr      = len_addr;
    mem_wdata      = r_handle;
    mem_raddr      = pos_addr;
    req_ready      = 1'b0;
    res_valid      = 1'b0;

    unique case (state)
      // Take no request while reset is held
      ulist_pkg::S_IDLE: begin
        req_ready = !rst;
        if (req_valid && req_ready) begin
          value_next  = '0;
          slot_next   = '0;
          status_next = ulist_pkg::ST_OK;
          state_next  = ulist_pkg::S_EXEC;
        end
      end

      // Check the request and issue its first access
      ulist_pkg::S_EXEC: begin
        state_next = ulist_pkg::S_DONE;
        unique case (r_mode)
          ulist_pkg::MODE_PUSH: begin
            if (zero_handle) begin
              status_next = ulist_pkg::ST_ZERO;
            end else if (full) begin
              status_next = ulist_pkg::ST_FULL;
            end else begin
              mem_we      = 1'b1;
              slot_next   = len_ext[ulist_pkg::POS_W-1:0];
              length_next = length + LW'(1);
            end
          end
          ulist_pkg::MODE_POP: begin
            if (empty) begin
              status_next = ulist_pkg::ST_EMPTY;
            end else begin
              mem_raddr  = last_addr;
              state_next = ulist_pkg::S_RD1;
            end
          end
          ulist_pkg::MODE_DELETE, ulist_pkg::MODE_READ: begin
            if (pos_ext >= len_ext) begin
              status_next = ulist_pkg::ST_BADPOS;
            end else begin
              state_next = ulist_pkg::S_RD1;
            end
          end
          ulist_pkg::MODE_INSERT: begin
            if (zero_handle) begin
              status_next = ulist_pkg::ST_ZERO;
            end else if (pos_ext > len_ext) begin
              status_next = ulist_pkg::ST_BADPOS;
            end else if (full) begin
              status_next = ulist_pkg::ST_FULL;
            end else if (pos_ext < len_ext) begin
              state_next = ulist_pkg::S_RD1;
            end else begin
              mem_we      = 1'b1;
              length_next = length + LW'(1);
            end
          end
          ulist_pkg::MODE_FIND: begin
            if (zero_handle) begin
              status_next = ulist_pkg::ST_ZERO;
            end else begin
              scan_idx_next  = '0;
              cmp_valid_next = 1'b0;
              state_next     = ulist_pkg::S_SCAN;
            end
          end
          ulist_pkg::MODE_SET: begin
            if (zero_handle) begin
              status_next = ulist_pkg::ST_ZERO;
            end else if (pos_ext >= len_ext) begin
              status_next = ulist_pkg::ST_BADPOS;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = pos_addr;
            end
          end
          default: begin
            // unused mode: nothing to do
          end
        endcase
      end

      // First read data is back
      ulist_pkg::S_RD1: begin
        unique case (r_mode)
          ulist_pkg::MODE_POP: begin
            value_next  = mem_rdata;
            length_next = length - LW'(1);
            state_next  = ulist_pkg::S_DONE;
          end
          ulist_pkg::MODE_DELETE: begin
            value_next = mem_rdata;
            mem_raddr  = last_addr;
            state_next = ulist_pkg::S_RD2;
          end
          ulist_pkg::MODE_INSERT: begin
            // move the displaced handle to the end
            mem_we     = 1'b1;
            mem_wdata  = mem_rdata;
            state_next = ulist_pkg::S_WR2;
          end
          default: begin
            value_next = mem_rdata;
            state_next = ulist_pkg::S_DONE;
          end
        endcase
      end

      // Delete: fill the hole with the last handle
      ulist_pkg::S_RD2: begin
        mem_we      = 1'b1;
        mem_waddr   = pos_addr;
        mem_wdata   = mem_rdata;
        length_next = length - LW'(1);
        state_next  = ulist_pkg::S_DONE;
      end

      // Insert: place the new handle
      ulist_pkg::S_WR2: begin
        mem_we      = 1'b1;
        mem_waddr   = pos_addr;
        length_next = length + LW'(1);
        state_next  = ulist_pkg::S_DONE;
      end

      // Find: one read issued and one compare each cycle
      ulist_pkg::S_SCAN: begin
        if (match) begin
          slot_next      = cmp_idx[ulist_pkg::POS_W-1:0];
          cmp_valid_next = 1'b0;
          state_next     = ulist_pkg::S_DONE;
        end else if (scan_idx < len_ext) begin
          mem_raddr      = scan_idx[AW-1:0];
          cmp_valid_next = 1'b1;
          cmp_idx_next   = scan_idx;
          scan_idx_next  = scan_idx + CMPW'(1);
        end else begin
          status_next    = ulist_pkg::ST_NOTFOUND;
          cmp_valid_next = 1'b0;
          state_next     = ulist_pkg::S_DONE;
        end
      end

      // Hand the result to the output register
      ulist_pkg::S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = ulist_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = ulist_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/unordered_handle_list.sv
// Top level of the unordered handle list: sequencer, storage, output register.
// Depends on ulist_pkg, ulist_seq and ulist_mem.
//
//   channel  signals                         direction
//   in       in_valid/in_ready, mode,        request in
//            handle, position
//   out      out_valid/out_ready, value,     result out
//            slot, count, status
//
// Each request goes through one sequencer and one storage port pair: push, set,
// insert at the end and errors check and end; pop and read make a read, delete
// two reads and a write, insert elsewhere a read and two writes; find reads one
// slot per cycle. in_ready is high only while the sequencer is idle; a result
// waiting in the output register does not block the next request, only the next
// result. Reset clears the length; storage contents are not cleared.
`default_nettype none

module unordered_handle_list #(
  parameter int CAPACITY = ulist_pkg::CAPACITY_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [2:0]                   mode,
  input  wire logic [ulist_pkg::DATA_W-1:0] handle,
  input  wire logic [ulist_pkg::POS_W-1:0]  position,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic      [ulist_pkg::DATA_W-1:0] value,
  output logic      [ulist_pkg::POS_W-1:0]  slot,
  output logic      [ulist_pkg::CNT_W-1:0]  count,
  output logic      [2:0]                   status
);

  localparam int AW = $clog2(CAPACITY);

  logic                         mem_we;
  logic [AW-1:0]                mem_waddr, mem_raddr;
  logic [ulist_pkg::DATA_W-1:0] mem_wdata, mem_rdata;
  logic                         res_valid, res_ready;
  ulist_pkg::res_t              res, out_res;

  ulist_seq #(.CAPACITY(CAPACITY)) u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (in_valid),
    .req_ready (in_ready),
    .req_mode  (mode),
    .req_handle(handle),
    .req_pos   (position),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  ulist_mem #(.CAPACITY(CAPACITY)) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // Output register: load when empty or being drained
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res <= res;
    end
  end

  assign value  = out_res.value;
  assign slot   = out_res.slot;
  assign count  = out_res.count;
  assign status = out_res.status;

endmodule

`default_nettype wire

FILE: sv/ulist_chk.sv
// Port checker of the unordered handle list, bound to the top level.
// Depends on ulist_pkg and unordered_handle_list_macros.svh.
`default_nettype none
`include "unordered_handle_list_macros.svh"

module ulist_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] value,
  input wire logic [5:0]  slot,
  input wire logic [6:0]  count,
  input wire logic [2:0]  status
);

  // A stalled result holds
  `UHL_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(value) && $stable(status), "result changed while stalled")

  // No result right after reset
  `UHL_ASSERT_ALL(a_rst_clear, rst |=> !out_valid, "result valid after reset")

  // The sequencer is busy the cycle after it takes a request
  `UHL_ASSERT(a_busy, in_valid && in_ready |=> !in_ready, "request taken while busy")

  // Errors return no handle and no slot; an empty pop reports a count of zero
  `UHL_ASSERT(a_err_zero, out_valid && status != ulist_pkg::ST_OK |-> value == '0 && slot == '0, "error with nonzero value or slot")
  `UHL_ASSERT(a_empty_cnt, out_valid && status == ulist_pkg::ST_EMPTY |-> count == '0, "empty status with nonzero count")

endmodule

bind unordered_handle_list ulist_chk u_chk (.*);

`default_nettype wire

FILE: verif/testbench.sv
// Self-checking testbench for the unordered handle list (unordered_handle_list).
// Depends on ulist_pkg for the mode and status codes and the result layout.
// Drives directed and random requests and checks each result against a built-in list model.
`timescale 1ns / 1ps

module testbench;
  import ulist_pkg::*;

  localparam int LIST_DEPTH = CAPACITY_DEF;
  localparam int CYCLE_LIMIT = 600000;
  localparam int STALL_LEN = 400;
  localparam int DRAIN_CYCLES = 80;
  localparam int REPORT_MAX = 10;
  localparam logic [2:0] MODE_UNUSED = 3'd7;

  typedef enum {MIX_GROW, MIX_SHRINK, MIX_EVEN} op_mix_e;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] mode = '0;
  logic [DATA_W-1:0] handle = '0;
  logic [POS_W-1:0] position = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [DATA_W-1:0] value;
  logic [POS_W-1:0] slot;
  logic [CNT_W-1:0] count;
  logic [2:0] status;

  // Model of the list contents, updated as each request is accepted
  logic [DATA_W-1:0] list_mem [LIST_DEPTH];
  int list_len = 0;
  res_t pending_results[$];

  int requests_sent = 0;
  int results_checked = 0;
  int mismatches = 0;
  int full_hits = 0;
  int empty_hits = 0;
  int cycle_count = 0;
  int tx_idle_pct = 20;
  int rx_idle_pct = 20;
  logic stall_armed = 1'b0;
  logic stall_armed_q = 1'b0;
  int stall_left = 0;

  unordered_handle_list dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .mode(mode),
    .handle(handle),
    .position(position),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .value(value),
    .slot(slot),
    .count(count),
    .status(status)
  );

  always #6 clk = ~clk;

  // Apply one request to the list model and return the result it should give
  function automatic res_t apply_list_op(input logic [2:0] m, input logic [DATA_W-1:0] h,
                                         input logic [POS_W-1:0] p);
    res_t r;
    int i;
    bit hit;
    r.value = '0;
    r.slot = '0;
    r.status = ST_OK;
    hit = 1'b0;
    case (m)
      MODE_PUSH: begin
        if (h == '0) r.status = ST_ZERO;
        else if (list_len >= LIST_DEPTH) r.status = ST_FULL;
        else begin
          list_mem[list_len] = h;
          r.slot = list_len[POS_W-1:0];
          list_len++;
        end
      end
      MODE_POP: begin
        if (list_len == 0) r.status = ST_EMPTY;
        else begin
          list_len--;
          r.value = list_mem[list_len];
        end
      end
      MODE_DELETE: begin
        if (int'(p) >= list_len) r.status = ST_BADPOS;
        else begin
          r.value = list_mem[p];
          list_len--;
          list_mem[p] = list_mem[list_len];
        end
      end
      MODE_INSERT: begin
        if (h == '0) r.status = ST_ZERO;
        else if (int'(p) > list_len) r.status = ST_BADPOS;
        else if (list_len >= LIST_DEPTH) r.status = ST_FULL;
        else begin
          // move the displaced handle to the end
          if (int'(p) < list_len) begin
            list_mem[list_len] = list_mem[p];
            list_mem[p] = h;
          end else begin
            list_mem[list_len] = h;
          end
          list_len++;
        end
      end
      MODE_FIND: begin
        if (h == '0) r.status = ST_ZERO;
        else begin
          r.status = ST_NOTFOUND;
          for (i = 0; i < list_len && !hit; i++) begin
            if (list_mem[i] == h) begin
              hit = 1'b1;
              r.slot = i[POS_W-1:0];
              r.status = ST_OK;
            end
          end
        end
      end
      MODE_SET: begin
        if (h == '0) r.status = ST_ZERO;
        else if (int'(p) >= list_len) r.status = ST_BADPOS;
        else list_mem[p] = h;
      end
      MODE_READ: begin
        if (int'(p) >= list_len) r.status = ST_BADPOS;
        else r.value = list_mem[p];
      end
      default: ;
    endcase
    r.count = list_len[CNT_W-1:0];
    return r;
  endfunction

  // Offer one request, hold it until accepted, then record the expected result
  task automatic issue_request(input logic [2:0] m, input logic [DATA_W-1:0] h,
                               input logic [POS_W-1:0] p);
    res_t r;
    if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    handle <= h;
    position <= p;
    do @(posedge clk); while (!in_ready);
    r = apply_list_op(m, h, p);
    if (r.status == ST_FULL) full_hits++;
    if (r.status == ST_EMPTY) empty_hits++;
    pending_results.push_back(r);
    requests_sent++;
  endtask

  // Pick a request with random content, weighted by the mix toward growing the list, shrinking it or neither
  task automatic issue_random(input op_mix_e mix);
    int r;
    int c_push, c_ins, c_find, c_set, c_read, c_del, c_pop;
    logic [2:0] m;
    logic [DATA_W-1:0] h;
    logic [POS_W-1:0] p;
    case (mix)
      MIX_GROW: begin
        c_push = 40; c_ins = 60; c_find = 70; c_set = 78; c_read = 86; c_del = 92; c_pop = 98;
      end
      MIX_SHRINK: begin
        c_push = 10; c_ins = 15; c_find = 25; c_set = 32; c_read = 40; c_del = 68; c_pop = 98;
      end
      default: begin
        c_push = 20; c_ins = 32; c_find = 50; c_set = 60; c_read = 72; c_del = 84; c_pop = 98;
      end
    endcase
    r = $urandom_range(99);
    if (r < c_push) m = MODE_PUSH;
    else if (r < c_ins) m = MODE_INSERT;
    else if (r < c_find) m = MODE_FIND;
    else if (r < c_set) m = MODE_SET;
    else if (r < c_read) m = MODE_READ;
    else if (r < c_del) m = MODE_DELETE;
    else if (r < c_pop) m = MODE_POP;
    else m = MODE_UNUSED;

    // stored handles make finds hit; small handles make duplicates
    r = $urandom_range(99);
    if (r < 4) h = '0;
    else if (r < 45 && list_len > 0) h = list_mem[$urandom_range(list_len - 1)];
    else if (r < 55) h = $urandom_range(1, 16);
    else if (r < 58) h = '1;
    else h = $urandom;

    // mostly positions up to the current length, some anywhere
    if ($urandom_range(99) < 80) p = POS_W'($urandom_range(list_len > LIST_DEPTH - 1 ?
                                                           LIST_DEPTH - 1 : list_len));
    else p = POS_W'($urandom_range(LIST_DEPTH - 1));
    issue_request(m, h, p);
  endtask

  // Empty-list errors, zero handles, extreme handles, every mode
  task automatic test_directed();
    issue_request(MODE_POP, 32'h0, 6'd0);
    issue_request(MODE_DELETE, 32'h1, 6'd0);
    issue_request(MODE_READ, 32'h1, 6'd0);
    issue_request(MODE_SET, 32'h5, 6'd0);
    issue_request(MODE_FIND, 32'hFFFF_FFFF, 6'd0);
    issue_request(MODE_PUSH, 32'h0, 6'd0);
    issue_request(MODE_INSERT, 32'h0, 6'd0);
    issue_request(MODE_FIND, 32'h0, 6'd0);
    issue_request(MODE_SET, 32'h0, 6'd0);
    issue_request(MODE_INSERT, 32'h3, 6'd1);
    issue_request(MODE_PUSH, 32'hFFFF_FFFF, 6'd0);
    issue_request(MODE_PUSH, 32'h1, 6'd63);
    issue_request(MODE_INSERT, 32'h8000_0000, 6'd2);
    issue_request(MODE_INSERT, 32'hAAAA_AAAA, 6'd0);
    issue_request(MODE_PUSH, 32'h1, 6'd0);
    issue_request(MODE_FIND, 32'h1, 6'd0);
    issue_request(MODE_FIND, 32'hFFFF_FFFF, 6'd0);
    issue_request(MODE_FIND, 32'h5555_5555, 6'd0);
    issue_request(MODE_SET, 32'h5555_5555, 6'd4);
    issue_request(MODE_READ, 32'h0, 6'd4);
    issue_request(MODE_READ, 32'h0, 6'd63);
    issue_request(MODE_DELETE, 32'h0, 6'd0);
    issue_request(MODE_DELETE, 32'h0, 6'd3);
    issue_request(MODE_UNUSED, 32'hFFFF_FFFF, 6'd63);
    issue_request(MODE_POP, 32'hFFFF_FFFF, 6'd63);
    issue_request(MODE_DELETE, 32'h0, 6'd2);
  endtask

  // Grow to capacity, work at full, then drain to empty
  task automatic test_fill_and_drain();
    int n;
    n = 0;
    while (list_len < LIST_DEPTH && n < 400) begin
      issue_random(MIX_GROW);
      n++;
    end
    repeat (40) issue_random(MIX_GROW);
    // scan the whole list for a handle that is unlikely to be there
    issue_request(MODE_FIND, 32'h7FFF_FFFE, 6'd0);
    n = 0;
    while (list_len > 0 && n < 400) begin
      issue_random(MIX_SHRINK);
      n++;
    end
    issue_random(MIX_SHRINK);
  endtask

  task automatic test_mixed_random();
    repeat (320) issue_random(MIX_EVEN);
  endtask

  // Long stretch with no idling on either side
  task automatic test_back_to_back();
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    repeat (100) issue_random(MIX_GROW);
    repeat (100) issue_random(MIX_SHRINK);
    tx_idle_pct = 20;
    rx_idle_pct <= 20;
  endtask

  // Hold off the result side while requests keep coming, so the input stalls
  task automatic test_output_stall();
    stall_armed <= 1'b1;
    repeat (30) issue_random(MIX_EVEN);
  endtask

  // Alternate growth and shrinkage to sweep many lengths
  task automatic test_wide_random();
    repeat (3) begin
      repeat (25) issue_random(MIX_GROW);
      repeat (25) issue_random(MIX_SHRINK);
    end
  endtask

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= REPORT_MAX) $display("ERROR at cycle %0d: %s", cycle_count, msg);
  endtask

  // Receive side: random backpressure plus one long hold-off
  always @(posedge clk) begin
    stall_armed_q <= stall_armed;
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_armed && !stall_armed_q) begin
      out_ready <= 1'b0;
      stall_left <= STALL_LEN - 1;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Compare each accepted result with the oldest expected one
  always @(posedge clk) begin
    res_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("unrequested result: value %h slot %0d count %0d status %0d",
                                value, slot, count, status));
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (want.value !== value || want.slot !== slot || want.count !== count ||
            want.status !== status)
          note_mismatch($sformatf(
            "res %0d: expected v=%h s=%0d c=%0d st=%0d, got v=%h s=%0d c=%0d st=%0d",
            results_checked, want.value, want.slot, want.count, want.status,
            value, slot, count, status));
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
               pending_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_fill_and_drain();
    test_mixed_random();
    test_back_to_back();
    test_output_stall();
    test_wide_random();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Ran %0d requests over all seven modes and the unused code; %0d results checked.",
             requests_sent, results_checked);
    $display("Full list refused %0d requests, empty list refused %0d pops; %0d mismatches.",
             full_hits, empty_hits, mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
